>>> design/assert_macros.svh
// Assertion macros shared by the decoder's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CHECK_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Implication checked at the next clock edge, outside reset.
`define CHECK_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> design/brle8_pkg.sv
// Package: types, codes and helpers of the RLE8 span decoder.
package brle8_pkg;

  localparam int PAL_DEPTH  = 256;
  localparam int PAL_AW     = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;
  localparam int COORD_BITS = 16;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [PAL_AW-1:0]     pal_addr_t;

  // Input function codes (tuser of the slave side).
  localparam logic [1:0] FUNC_PAL_WR = 2'd0;
  localparam logic [1:0] FUNC_BYTE   = 2'd1;
  localparam logic [1:0] FUNC_END    = 2'd2;

  // Result kinds (tuser of the master side).
  localparam logic [1:0] KIND_SPAN  = 2'd0;
  localparam logic [1:0] KIND_EOB   = 2'd1;
  localparam logic [1:0] KIND_TRUNC = 2'd2;

  // Escape codes after a zero command byte.
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RUN_COLOR,
    PH_ESCAPE,
    PH_DELTA_X,
    PH_DELTA_Y,
    PH_ABS_PIXEL,
    PH_ABS_PAD,
    PH_DONE
  } phase_t;

  // Palette port request from the parser.
  typedef struct packed {
    logic      wr_en;
    logic      rd_en;
    pal_addr_t addr;
    logic [31:0] wdata;
  } pal_req_t;

  // Saturating add of an 8-bit step to a coordinate.
  function automatic coord_t sat_add(coord_t a, logic [7:0] b);
    logic [COORD_BITS:0] s;
    s = {1'b0, a} + (COORD_BITS+1)'(b);
    return s[COORD_BITS] ? {COORD_BITS{1'b1}} : s[COORD_BITS-1:0];
  endfunction

  // Clamp a coordinate to the 16-bit result field.
  function automatic logic [15:0] out16(coord_t v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'h0FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  // True when an 8-bit index falls inside the palette.
  function automatic logic pal_in_range(logic [7:0] idx);
    return 32'(idx) < PAL_DEPTH;
  endfunction

endpackage

>>> design/brle8_palette.sv
// Palette memory with per-entry valid flags; unwritten entries read as zero.
module brle8_palette (
  input  logic                clk,
  input  logic                rst,
  input  brle8_pkg::pal_req_t req,
  output logic [31:0]         rd_data
);
  import brle8_pkg::*;

  logic [31:0]          mem [PAL_DEPTH];
  logic [PAL_DEPTH-1:0] vld;
  logic [31:0]          rd_q;
  logic                 rd_vld;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.addr];
    end
  end

  // Valid flags: cleared together at reset, set on write
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld <= vld[req.addr];
      end
    end
  end

  // Mask entries never written since reset
  assign rd_data = rd_vld ? rd_q : 32'd0;

`include "assert_macros.svh"

  `CHECK_IMPL(a_one_port_op, req.wr_en, !req.rd_en, "palette read and write in one cycle")
  `CHECK_NEXT(a_wr_sets_vld, req.wr_en, vld[$past(req.addr)], "palette write left entry invalid")

endmodule

>>> design/bmp_rle8_span_decoder.sv
// Rate: one input transaction per clock while the master side keeps up.
// Palette writes, stream bytes and end-of-input marks are parsed in the
// cycle they are accepted; a resulting span, end-of-bitmap or truncation
// transaction passes the read stage, with the palette memory read, and the
// output register to the master side. Results are one per item at most, so
// the block only holds the input back while both its read stage and output
// register are full and the master side stalls. The palette is cleared at
// reset at once through per-entry valid flags; no clearing pass is needed.
// End of input returns the cursor to (0, 0) and keeps the palette.
module bmp_rle8_span_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // pal_index[7:0], pal_color[39:8], data_byte[47:40]
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // x_start[15:0], row[31:16], span_length[39:32],
                                 // color[71:40]
  output logic [1:0]  m_tuser    // kind[1:0]
);
  import brle8_pkg::*;

  // Parser registers
  phase_t      phase, phase_next;
  logic [7:0]  pend, pend_next;
  coord_t      cur_x, cur_x_next;
  coord_t      cur_y, cur_y_next;
  logic [7:0]  held_dx, held_dx_next;
  logic        abs_odd, abs_odd_next;

  // Read stage and output register
  logic        s1_valid;
  logic [1:0]  s1_kind;
  logic [15:0] s1_x, s1_row;
  logic [7:0]  s1_len;
  logic        s1_use_color;
  logic        s1_move;

  logic        out_valid;
  logic [1:0]  out_kind;
  logic [15:0] out_x, out_row;
  logic [7:0]  out_len;
  logic [31:0] out_color;

  // Per-item decode
  logic        acc;
  logic [1:0]  func;
  logic [7:0]  pal_index, data_byte;
  logic [31:0] pal_color;
  logic        res_valid;
  logic [1:0]  res_kind;
  logic [15:0] res_x, res_row;
  logic [7:0]  res_len;
  logic        res_use_color;
  pal_req_t    pal_req;
  logic [31:0] pal_rdata;

  assign func      = s_tuser;
  assign pal_index = s_tdata[7:0];
  assign pal_color = s_tdata[39:8];
  assign data_byte = s_tdata[47:40];

  // Handshake: stage one advances when the output register frees up
  assign s1_move  = !out_valid || m_tready;
  assign s_tready = !s1_valid || s1_move;
  assign acc      = s_tvalid && s_tready;

  // Next parser state
  always_comb begin
    phase_next   = phase;
    pend_next    = pend;
    cur_x_next   = cur_x;
    cur_y_next   = cur_y;
    held_dx_next = held_dx;
    abs_odd_next = abs_odd;
    if (acc) begin
      case (func)
        FUNC_END: begin
          phase_next   = PH_IDLE;
          pend_next    = '0;
          cur_x_next   = '0;
          cur_y_next   = '0;
          held_dx_next = '0;
          abs_odd_next = 1'b0;
        end
        FUNC_BYTE: begin
          unique case (phase)
            PH_IDLE: begin
              if (data_byte != 8'd0) begin
                pend_next  = data_byte;
                phase_next = PH_RUN_COLOR;
              end else begin
                phase_next = PH_ESCAPE;
              end
            end
            PH_RUN_COLOR: begin
              cur_x_next = sat_add(cur_x, pend);
              pend_next  = '0;
              phase_next = PH_IDLE;
            end
            PH_ESCAPE: begin
              if (data_byte == ESC_EOL) begin
                cur_x_next = '0;
                cur_y_next = sat_add(cur_y, 8'd1);
                phase_next = PH_IDLE;
              end else if (data_byte == ESC_EOB) begin
                phase_next = PH_DONE;
              end else if (data_byte == ESC_DELTA) begin
                phase_next = PH_DELTA_X;
              end else begin
                pend_next    = data_byte;
                abs_odd_next = data_byte[0];
                phase_next   = PH_ABS_PIXEL;
              end
            end
            PH_DELTA_X: begin
              held_dx_next = data_byte;
              phase_next   = PH_DELTA_Y;
            end
            PH_DELTA_Y: begin
              cur_x_next   = sat_add(cur_x, held_dx);
              cur_y_next   = sat_add(cur_y, data_byte);
              held_dx_next = '0;
              phase_next   = PH_IDLE;
            end
            PH_ABS_PIXEL: begin
              cur_x_next = sat_add(cur_x, 8'd1);
              if ((pend == 8'd1) || (pend == 8'd0)) begin
                pend_next    = '0;
                phase_next   = abs_odd ? PH_ABS_PAD : PH_IDLE;
                abs_odd_next = 1'b0;
              end else begin
                pend_next = pend - 8'd1;
              end
            end
            PH_ABS_PAD: phase_next = PH_IDLE;
            PH_DONE:    phase_next = PH_DONE;
            default:    phase_next = phase;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Result and palette request of the accepted item
  always_comb begin
    res_valid     = 1'b0;
    res_kind      = KIND_SPAN;
    res_x         = '0;
    res_row       = '0;
    res_len       = '0;
    res_use_color = 1'b0;
    pal_req.wr_en = 1'b0;
    pal_req.rd_en = 1'b0;
    pal_req.addr  = '0;
    pal_req.wdata = pal_color;
    if (acc) begin
      case (func)
        FUNC_PAL_WR: begin
          pal_req.wr_en = pal_in_range(pal_index);
          pal_req.addr  = pal_index[PAL_AW-1:0];
        end
        FUNC_END: begin
          res_valid = (phase != PH_DONE);
          res_kind  = KIND_TRUNC;
        end
        FUNC_BYTE: begin
          unique case (phase)
            PH_RUN_COLOR, PH_ABS_PIXEL: begin
              res_valid     = 1'b1;
              res_kind      = KIND_SPAN;
              res_x         = out16(cur_x);
              res_row       = out16(cur_y);
              res_len       = (phase == PH_RUN_COLOR) ? pend : 8'd1;
              res_use_color = pal_in_range(data_byte);
              pal_req.rd_en = pal_in_range(data_byte);
              pal_req.addr  = data_byte[PAL_AW-1:0];
            end
            PH_ESCAPE: begin
              res_valid = (data_byte == ESC_EOB);
              res_kind  = KIND_EOB;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      pend    <= '0;
      cur_x   <= '0;
      cur_y   <= '0;
      held_dx <= '0;
      abs_odd <= 1'b0;
    end else begin
      phase   <= phase_next;
      pend    <= pend_next;
      cur_x   <= cur_x_next;
      cur_y   <= cur_y_next;
      held_dx <= held_dx_next;
      abs_odd <= abs_odd_next;
    end
  end

  brle8_palette u_palette (
    .clk     (clk),
    .rst     (rst),
    .req     (pal_req),
    .rd_data (pal_rdata)
  );

  // Read stage: hold result fields while the palette read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= res_valid;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_kind      <= res_kind;
      s1_x         <= res_x;
      s1_row       <= res_row;
      s1_len       <= res_len;
      s1_use_color <= res_use_color;
    end
  end

  // Output register: load from the read stage, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid) begin
      out_kind  <= s1_kind;
      out_x     <= s1_x;
      out_row   <= s1_row;
      out_len   <= s1_len;
      out_color <= s1_use_color ? pal_rdata : 32'd0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {out_color, out_len, out_row, out_x};

`include "assert_macros.svh"

  `CHECK_IMPL(a_stall_blocks_in, s1_valid && !s1_move, !s_tready,
              "input accepted while read stage is blocked")
  `CHECK_IMPL(a_nonspan_zero, out_valid && (out_kind != KIND_SPAN), m_tdata == 72'd0,
              "non-span result carries data")
  `CHECK_NEXT(a_done_silent, acc && (func == FUNC_BYTE) && (phase == PH_DONE), !s1_valid,
              "byte after end of bitmap produced a result")

endmodule

>>> dv/rle8_span_checker.sv
// Span checker: decodes the accepted input stream and compares every result transaction.
module rle8_span_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,   // pal_index[7:0], pal_color[39:8], data_byte[47:40]
  input  logic [1:0]  s_tuser,   // func[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,   // x_start[15:0], row[31:16], span_length[39:32],
                                 // color[71:40]
  input  logic [1:0]  m_tuser,   // kind[1:0]
  output int          error_count,
  output int          results_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import brle8_pkg::*;

  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] x_start;
    logic [15:0] row;
    logic [7:0]  span_length;
    logic [31:0] color;
  } span_rec_t;

  // Decoder state mirrored from the accepted transactions
  phase_t      phase;
  logic [7:0]  pixels_left;
  coord_t      cur_x;
  coord_t      cur_y;
  logic [7:0]  dx_hold;
  logic        pad_due;
  logic [31:0] pal_mem [PAL_DEPTH];
  span_rec_t   decoded_q [$];
  int          fails;

  // Saturating cursor move
  function automatic coord_t step_coord(coord_t base, logic [7:0] delta);
    logic [63:0] sum;
    logic [63:0] ceiling;
    ceiling = (64'd1 << COORD_BITS) - 64'd1;
    sum = 64'(base) + 64'(delta);
    return (sum > ceiling) ? coord_t'(ceiling) : coord_t'(sum);
  endfunction

  // Clamp a cursor to the 16-bit result field
  function automatic logic [15:0] clip16(coord_t v);
    return (64'(v) > 64'hFFFF) ? 16'hFFFF : 16'(v);
  endfunction

  function automatic logic [31:0] pal_lookup(logic [7:0] idx);
    return (32'(idx) < PAL_DEPTH) ? pal_mem[idx] : 32'd0;
  endfunction

  task automatic emit(logic [1:0] kind, coord_t x, coord_t y, logic [7:0] len,
                      logic [31:0] col);
    span_rec_t rec;
    rec.kind        = kind;
    rec.x_start     = clip16(x);
    rec.row         = clip16(y);
    rec.span_length = len;
    rec.color       = col;
    decoded_q.push_back(rec);
  endtask

  task automatic rewind();
    phase       = PH_IDLE;
    pixels_left = '0;
    cur_x       = '0;
    cur_y       = '0;
    dx_hold     = '0;
    pad_due     = 1'b0;
  endtask

  // Advance the decoder by one input transaction
  task automatic decode_item(logic [1:0] func, logic [7:0] idx, logic [31:0] colr,
                             logic [7:0] b);
    coord_t x0;
    case (func)
      FUNC_PAL_WR: begin
        if (32'(idx) < PAL_DEPTH) pal_mem[idx] = colr;
      end
      FUNC_END: begin
        if (phase != PH_DONE) emit(KIND_TRUNC, '0, '0, '0, '0);
        rewind();
      end
      FUNC_BYTE: begin
        case (phase)
          PH_IDLE: begin
            if (b != 8'd0) begin
              pixels_left = b;
              phase = PH_RUN_COLOR;
            end else begin
              phase = PH_ESCAPE;
            end
          end
          PH_RUN_COLOR: begin
            x0 = cur_x;
            cur_x = step_coord(cur_x, pixels_left);
            emit(KIND_SPAN, x0, cur_y, pixels_left, pal_lookup(b));
            pixels_left = '0;
            phase = PH_IDLE;
          end
          PH_ESCAPE: begin
            if (b == ESC_EOL) begin
              cur_x = '0;
              cur_y = step_coord(cur_y, 8'd1);
              phase = PH_IDLE;
            end else if (b == ESC_EOB) begin
              phase = PH_DONE;
              emit(KIND_EOB, '0, '0, '0, '0);
            end else if (b == ESC_DELTA) begin
              phase = PH_DELTA_X;
            end else begin
              pixels_left = b;
              pad_due = b[0];
              phase = PH_ABS_PIXEL;
            end
          end
          PH_DELTA_X: begin
            dx_hold = b;
            phase = PH_DELTA_Y;
          end
          PH_DELTA_Y: begin
            cur_x = step_coord(cur_x, dx_hold);
            cur_y = step_coord(cur_y, b);
            dx_hold = '0;
            phase = PH_IDLE;
          end
          PH_ABS_PIXEL: begin
            x0 = cur_x;
            cur_x = step_coord(cur_x, 8'd1);
            if (pixels_left != 8'd0) pixels_left = pixels_left - 8'd1;
            if (pixels_left == 8'd0) begin
              phase = pad_due ? PH_ABS_PAD : PH_IDLE;
              pad_due = 1'b0;
            end
            emit(KIND_SPAN, x0, cur_y, 8'd1, pal_lookup(b));
          end
          PH_ABS_PAD: phase = PH_IDLE;
          default: ;
        endcase
      end
      default: ;
    endcase
  endtask

  // Watch both channels at each rising edge
  always @(posedge clk) begin
    span_rec_t got;
    span_rec_t want;
    if (rst) begin
      rewind();
      for (int i = 0; i < PAL_DEPTH; i++) pal_mem[i] = '0;
      decoded_q.delete();
      fails = 0;
    end else begin
      if (s_tvalid && s_tready)
        decode_item(s_tuser, s_tdata[7:0], s_tdata[39:8], s_tdata[47:40]);
      if (m_tvalid && m_tready) begin
        got.kind        = m_tuser;
        got.x_start     = m_tdata[15:0];
        got.row         = m_tdata[31:16];
        got.span_length = m_tdata[39:32];
        got.color       = m_tdata[71:40];
        if (decoded_q.size() == 0) begin
          fails++;
          if (fails <= REPORT_CAP)
            $display("%0t: unexpected result: kind=%0d x=%0d row=%0d len=%0d color=%08h",
                     $time, got.kind, got.x_start, got.row, got.span_length, got.color);
        end else begin
          want = decoded_q.pop_front();
          if (got.kind !== want.kind || got.x_start !== want.x_start ||
              got.row !== want.row || got.span_length !== want.span_length ||
              got.color !== want.color) begin
            fails++;
            if (fails <= REPORT_CAP)
              $display({"%0t: result mismatch: expected kind=%0d x=%0d row=%0d len=%0d ",
                        "color=%08h, actual kind=%0d x=%0d row=%0d len=%0d color=%08h"},
                       $time, want.kind, want.x_start, want.row, want.span_length,
                       want.color, got.kind, got.x_start, got.row, got.span_length,
                       got.color);
          end
        end
      end
    end
    error_count <= fails;
    results_due <= decoded_q.size();
  end

endmodule

>>> dv/testbench.sv
// Testbench top: clock, reset, stimulus for the RLE8 span decoder and the final verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import brle8_pkg::*;

  localparam int          HALF_PERIOD  = 4;
  localparam int          RESET_CYCLES = 9;
  localparam int          LIMIT_CYCLES = 400000;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          PHASE_ITEMS  = 130;
  localparam int          FAR_STEPS    = 24;
  localparam logic [1:0]  FUNC_IGNORED = 2'd3;
  localparam logic [7:0]  CMD_ESCAPE   = 8'd0;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;   // pal_index[7:0], pal_color[39:8], data_byte[47:40]
  logic [1:0]  s_tuser  = '0;   // func[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;         // x_start[15:0], row[31:16], span_length[39:32],
                                // color[71:40]
  logic [1:0]  m_tuser;         // kind[1:0]

  int error_count;
  int results_due;
  int send_idle_pct = 10;
  int recv_idle_pct = 48;
  int items_sent    = 0;
  int cycle_count   = 0;

  bmp_rle8_span_decoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  rle8_span_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .error_count (error_count),
    .results_due (results_due)
  );

  always #HALF_PERIOD clk = ~clk;

  // Random backpressure on the result side
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Offer one transaction, with random gaps ahead of it, and hold until accepted
  task automatic send(logic [1:0] func, logic [7:0] idx, logic [31:0] colr,
                      logic [7:0] b, bit counted);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {b, colr, idx};
    @(posedge clk iff s_tready);
    if (counted) items_sent++;
  endtask

  task automatic put_byte(logic [7:0] b);
    send(FUNC_BYTE, 8'($urandom), $urandom, b, 1'b1);
  endtask

  task automatic put_pal(logic [7:0] idx, logic [31:0] colr);
    send(FUNC_PAL_WR, idx, colr, 8'($urandom), 1'b1);
  endtask

  task automatic put_end();
    send(FUNC_END, 8'($urandom), $urandom, 8'($urandom), 1'b1);
  endtask

  task automatic put_absolute(int n);
    put_byte(CMD_ESCAPE);
    put_byte(8'(n));
    repeat (n) put_byte(8'($urandom));
    if (n % 2 == 1) put_byte(8'($urandom));
  endtask

  task automatic put_delta(logic [7:0] dx, logic [7:0] dy);
    put_byte(CMD_ESCAPE);
    put_byte(ESC_DELTA);
    put_byte(dx);
    put_byte(dy);
  endtask

  // One bitmap of random commands, closed properly or cut short
  task automatic random_bitmap();
    int n;
    if ($urandom_range(99) < 10) begin
      // raw noise bytes
      repeat ($urandom_range(1, 24)) put_byte(8'($urandom));
      put_end();
    end else begin
      repeat ($urandom_range(1, 10)) begin
        n = $urandom_range(99);
        if (n < 35) begin
          put_byte(8'($urandom_range(1, 255)));
          put_byte(8'($urandom));
        end else if (n < 55) begin
          put_absolute(($urandom_range(19) == 0) ? $urandom_range(3, 255)
                                                 : $urandom_range(3, 8));
        end else if (n < 70) begin
          put_byte(CMD_ESCAPE);
          put_byte(ESC_EOL);
        end else if (n < 85) begin
          put_delta(8'($urandom), 8'($urandom));
        end else if (n < 93) begin
          put_pal(8'($urandom), $urandom);
        end else begin
          send(FUNC_IGNORED, 8'($urandom), $urandom, 8'($urandom), 1'b0);
        end
      end
      if ($urandom_range(99) < 75) begin
        put_byte(CMD_ESCAPE);
        put_byte(ESC_EOB);
        // trailing bytes are dropped until end of input
        repeat ($urandom_range(0, 3))
          send(FUNC_BYTE, 8'($urandom), $urandom, 8'($urandom), 1'b0);
      end else begin
        case ($urandom_range(5))
          1: put_byte(8'($urandom_range(1, 255)));
          2: put_byte(CMD_ESCAPE);
          3: begin
            put_byte(CMD_ESCAPE);
            put_byte(ESC_DELTA);
            if ($urandom_range(1) == 1) put_byte(8'($urandom));
          end
          4: begin
            put_byte(CMD_ESCAPE);
            put_byte(8'($urandom_range(3, 9)));
            put_byte(8'($urandom));
          end
          5: begin
            put_byte(CMD_ESCAPE);
            put_byte(8'd3);
            repeat (3) put_byte(8'($urandom));
          end
          default: ;
        endcase
      end
      put_end();
    end
  endtask

  // Walk the cursor far out on both axes, then draw there
  task automatic far_bitmap();
    repeat (FAR_STEPS)
      put_delta(8'($urandom_range(250, 255)), 8'($urandom_range(250, 255)));
    put_byte(8'($urandom_range(1, 255)));
    put_byte(8'($urandom));
    put_absolute(3);
    put_delta(8'd255, 8'd255);
    put_byte(CMD_ESCAPE);
    put_byte(ESC_EOL);
    put_byte(8'd200);
    put_byte(8'($urandom));
    put_byte(CMD_ESCAPE);
    put_byte(ESC_EOB);
    put_end();
  endtask

  initial begin
    int start;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every escape, pad byte, ignored items, truncation
    put_pal(8'd0, 32'hFFFF_FFFF);
    put_pal(8'd255, 32'h8000_0001);
    put_byte(8'd255);
    put_byte(8'd255);
    put_byte(8'd1);
    put_byte(8'd0);
    put_byte(CMD_ESCAPE);
    put_byte(8'd3);
    put_byte(8'd0);
    put_byte(8'd255);
    put_byte(8'd7);
    put_byte(8'hFF);
    put_delta(8'd255, 8'd255);
    put_byte(CMD_ESCAPE);
    put_byte(ESC_EOL);
    put_byte(CMD_ESCAPE);
    put_byte(ESC_EOB);
    send(FUNC_BYTE, 8'd0, 32'd0, 8'd9, 1'b0);
    send(FUNC_IGNORED, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 1'b0);
    put_end();
    put_byte(8'd5);
    put_end();

    // Random: three idling profiles, far-cursor bitmap in the last
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 48 : 0;
      recv_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 10 : 0;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) random_bitmap();
    end
    far_bitmap();
    s_tvalid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    do @(posedge clk); while (results_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
